// ----- design/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsd_pkg;

  localparam logic [7:0]  MASK_BIT      = 8'h80;
  localparam logic [6:0]  LEN_EXT16     = 7'd126;
  localparam logic [6:0]  LEN_EXT64     = 7'd127;
  localparam logic [3:0]  CLOSE_OPCODE  = 4'h8;
  localparam logic [3:0]  EXT16_BYTES   = 4'd2;
  localparam logic [3:0]  EXT64_BYTES   = 4'd8;
  localparam logic [23:0] MAX_PAYLOAD_RST = 24'd4194304;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_MASKED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 2'd1;

  typedef enum logic [1:0] {
    OUT_MSG      = 2'd0,
    OUT_CLOSE    = 2'd1,
    OUT_MASK_ERR = 2'd2,
    OUT_LEN_ERR  = 2'd3
  } outcome_t;

  // one classified item from the parser to the output side
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] key;
    logic       present;
    logic [3:0] opcode;
    logic       last;
    outcome_t   outcome;
  } cmd_t;

endpackage

// ----- design/wsd_front.sv -----
// ----------------------------------------------------------------------------
// wsd_front
// header parser: tracks frame phase, length, mask key and pushes one command
// per payload byte, empty frame or error
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_front import wsd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 take,
  output logic                 push,
  output cmd_t                 cmd
);

  localparam int unsigned LW = (COUNT_BITS > 24) ? COUNT_BITS : 24;

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_EXT  = 6'b000100,
    PH_KEY  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_HALT = 6'b100000
  } phase_t;

  phase_t                phase, phase_next;
  logic                  expect_masked;
  logic [23:0]           max_payload;
  logic [3:0]            cur_opcode, cur_opcode_next;
  logic                  frame_masked, frame_masked_next;
  logic [3:0]            ext_left, ext_left_next;
  logic [COUNT_BITS-1:0] length_acc, length_acc_next;
  logic                  length_big, length_big_next;
  logic [31:0]           mask_key, mask_key_next;
  logic [1:0]            key_cnt, key_cnt_next;
  logic [COUNT_BITS-1:0] payload_left, payload_left_next;
  logic [1:0]            payload_pos, payload_pos_next;

  logic [COUNT_BITS+7:0] acc_shift;
  logic                  len_done;
  logic [COUNT_BITS-1:0] len_val;
  logic                  len_big;
  logic                  hdr_done;
  logic [COUNT_BITS-1:0] hdr_len;
  logic [7:0]            key_byte;
  outcome_t              frame_outc;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_masked <= 1'b0;
      max_payload   <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXPECT_MASKED: expect_masked <= cfg_data[0];
        CFG_MAX_PAYLOAD:   max_payload   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign acc_shift  = {length_acc, in_byte};
  assign frame_outc = (cur_opcode == CLOSE_OPCODE) ? OUT_CLOSE : OUT_MSG;

  always_comb begin
    case (payload_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    if (!frame_masked) key_byte = 8'h00;
  end

  always_comb begin
    phase_next        = phase;
    cur_opcode_next   = cur_opcode;
    frame_masked_next = frame_masked;
    ext_left_next     = ext_left;
    length_acc_next   = length_acc;
    length_big_next   = length_big;
    mask_key_next     = mask_key;
    key_cnt_next      = key_cnt;
    payload_left_next = payload_left;
    payload_pos_next  = payload_pos;
    push              = 1'b0;
    cmd               = '{raw: 8'h00, key: 8'h00, present: 1'b0, opcode: cur_opcode,
                          last: 1'b1, outcome: frame_outc};
    len_done          = 1'b0;
    len_val           = '0;
    len_big           = 1'b0;
    hdr_done          = 1'b0;
    hdr_len           = payload_left;

    if (take) begin
      unique case (phase)
        PH_HDR0: begin
          cur_opcode_next = in_byte[3:0];
          phase_next      = PH_HDR1;
        end
        PH_HDR1: begin
          frame_masked_next = in_byte[7];
          if (in_byte[7] != expect_masked) begin
            push        = 1'b1;
            cmd.outcome = OUT_MASK_ERR;
            phase_next  = PH_HALT;
          end else begin
            length_acc_next = '0;
            length_big_next = 1'b0;
            if (in_byte[6:0] == LEN_EXT16) begin
              ext_left_next = EXT16_BYTES;
              phase_next    = PH_EXT;
            end else if (in_byte[6:0] == LEN_EXT64) begin
              ext_left_next = EXT64_BYTES;
              phase_next    = PH_EXT;
            end else begin
              len_done = 1'b1;
              len_val  = COUNT_BITS'(in_byte[6:0]);
            end
          end
        end
        PH_EXT: begin
          length_acc_next = acc_shift[COUNT_BITS-1:0];
          length_big_next = length_big | (|acc_shift[COUNT_BITS+7:COUNT_BITS]);
          ext_left_next   = ext_left - 4'd1;
          if (ext_left == 4'd1) begin
            len_done = 1'b1;
            len_val  = length_acc_next;
            len_big  = length_big_next;
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], in_byte};
          key_cnt_next  = key_cnt + 2'd1;
          if (key_cnt == 2'd3) hdr_done = 1'b1;
        end
        PH_DATA: begin
          payload_pos_next  = payload_pos + 2'd1;
          payload_left_next = payload_left - COUNT_BITS'(1);
          push              = 1'b1;
          cmd.raw           = in_byte;
          cmd.key           = key_byte;
          cmd.present       = 1'b1;
          cmd.last          = (payload_left == COUNT_BITS'(1));
          if (payload_left == COUNT_BITS'(1)) phase_next = PH_HDR0;
        end
        PH_HALT: ;
        default: phase_next = PH_HALT;
      endcase

      // length complete: range check, then key or payload
      if (len_done) begin
        if (len_big || (LW'(len_val) > LW'(max_payload))) begin
          push        = 1'b1;
          cmd.outcome = OUT_LEN_ERR;
          phase_next  = PH_HALT;
        end else begin
          payload_left_next = len_val;
          if (frame_masked_next) begin
            key_cnt_next  = 2'd0;
            mask_key_next = 32'h0;
            phase_next    = PH_KEY;
          end else begin
            hdr_done = 1'b1;
            hdr_len  = len_val;
          end
        end
      end

      // header complete: empty frame reports at once
      if (hdr_done) begin
        payload_pos_next = 2'd0;
        if (hdr_len == '0) begin
          push       = 1'b1;
          phase_next = PH_HDR0;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      frame_masked <= 1'b0;
      ext_left     <= 4'd0;
      key_cnt      <= 2'd0;
      payload_left <= '0;
      payload_pos  <= 2'd0;
    end else begin
      phase        <= phase_next;
      frame_masked <= frame_masked_next;
      ext_left     <= ext_left_next;
      key_cnt      <= key_cnt_next;
      payload_left <= payload_left_next;
      payload_pos  <= payload_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_opcode <= cur_opcode_next;
    length_acc <= length_acc_next;
    length_big <= length_big_next;
    mask_key   <= mask_key_next;
  end

endmodule

// ----- design/wsd_queue.sv -----
// ----------------------------------------------------------------------------
// wsd_queue
// two-entry command queue between parser and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_queue import wsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- design/wsd_back.sv -----
// ----------------------------------------------------------------------------
// wsd_back
// output stage: unmasks the payload byte and holds the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_back import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       data_present,
  output logic [3:0] frame_opcode,
  output logic       frame_end,
  output logic [1:0] outcome
);

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_byte    <= q_head.raw ^ q_head.key;
      data_present <= q_head.present;
      frame_opcode <= q_head.opcode;
      frame_end    <= q_head.last;
      outcome      <= q_head.outcome;
    end
  end

endmodule

// ----- design/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser with payload unmasking
// ----------------------------------------------------------------------------
//  channel | signals                               | dir | handshake
//  input   | in_byte                               | in  | in_valid / in_stall
//  output  | data_byte data_present frame_opcode   | out | out_valid / out_stall
//          | frame_end outcome                     |     |
//  config  | cfg_index cfg_data                    | in  | cfg_valid / cfg_ready
//
//  one byte per cycle sustained while in_stall is low; a result reaches the
//  outputs from its byte through parser -> queue -> output register
//  in_stall rises only when the two-entry queue is full
//  rst is synchronous; after an error the parser drops every byte until rst
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           data_byte,
  output logic                 data_present,
  output logic [3:0]           frame_opcode,
  output logic                 frame_end,
  output logic [1:0]           outcome,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data
);

  logic take, push, pop, q_full, q_empty;
  cmd_t push_cmd, q_head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !q_full;

  wsd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .push      (push),
    .cmd       (push_cmd)
  );

  wsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  wsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .data_present (data_present),
    .frame_opcode (frame_opcode),
    .frame_end    (frame_end),
    .outcome      (outcome)
  );

endmodule

// ----- design/wsd_checker.sv -----
// ----------------------------------------------------------------------------
// wsd_checker
// port-level checks on the deframer results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_checker import wsd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte,
  input logic       data_present,
  input logic [3:0] frame_opcode,
  input logic       frame_end,
  input logic [1:0] outcome
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(outcome)
      && $stable(frame_end))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_present |-> data_byte == 8'h00 && frame_end)
    else $error("result without data is not a zero frame end");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_MASK_ERR || outcome == OUT_LEN_ERR)
      |-> frame_end && !data_present)
    else $error("error result carries data");

  a_close_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_CLOSE || outcome == OUT_MSG)
      |-> ((outcome == OUT_CLOSE) == (frame_opcode == CLOSE_OPCODE)))
    else $error("close outcome does not match opcode");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .data_byte    (data_byte),
  .data_present (data_present),
  .frame_opcode (frame_opcode),
  .frame_end    (frame_end),
  .outcome      (outcome)
);
